// ----- rtl/kmac_pkg.sv -----
// Shared types and constants for the knob menu autopilot controller.
// Used by kmac_ctrl, kmac_dp and knob_menu_autopilot_controller.
package kmac_pkg;

  localparam int MODE_COUNT   = 4;
  localparam int MAX_DISPLAYS = 16;
  localparam int MAX_VIEWS    = 16;

  // one full turn in centidegrees
  localparam logic [15:0] FULL_TURN = 16'd36000;

  // event codes
  localparam logic [2:0] EV_CW     = 3'd0;
  localparam logic [2:0] EV_CCW    = 3'd1;
  localparam logic [2:0] EV_CLICK  = 3'd2;
  localparam logic [2:0] EV_LONG   = 3'd3;
  localparam logic [2:0] EV_DOUBLE = 3'd4;

  // menu levels
  localparam logic [1:0] LVL_HOME    = 2'd0;
  localparam logic [1:0] LVL_MODE    = 2'd1;
  localparam logic [1:0] LVL_DISPLAY = 2'd2;
  localparam logic [1:0] LVL_VIEW    = 2'd3;

  // action kinds
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_MODE   = 2'd1;
  localparam logic [1:0] ACT_TARGET = 2'd2;
  localparam logic [1:0] ACT_VIEW   = 2'd3;

  // autopilot modes
  localparam logic [1:0] MODE_STANDBY = 2'd0;
  localparam logic [1:0] MODE_AUTO    = 2'd1;

  // configuration register indexes
  localparam logic REG_SMALL_STEP = 1'b0;
  localparam logic REG_BIG_STEP   = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic        held;
    logic        heading_valid;
    logic [15:0] heading_centideg;
    logic        ap_target_valid;
    logic [15:0] ap_target_centideg;
    logic [4:0]  num_displays;
    logic [4:0]  num_views;
  } req_t;

  typedef struct packed {
    logic [1:0]  action_kind;
    logic [1:0]  mode_index;
    logic [15:0] target_centideg;
    logic [3:0]  display_index;
    logic [3:0]  view_index;
    logic [1:0]  menu_level;
    logic [3:0]  highlight_index;
  } rsp_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic load;      // capture request
    logic prep;      // reduce seed, form step, start remainder
    logic div_step;  // one remainder iteration
    logic exec;      // commit state, load result register
  } cmd_t;

endpackage

// ----- rtl/kmac_ctrl.sv -----
// Sequencer for the knob menu controller: request handshake, step timing
// and result valid. Depends on kmac_pkg.
module kmac_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output kmac_pkg::cmd_t  cmd
);
  import kmac_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state, state_next;
  logic [1:0] cnt, cnt_next;
  logic       rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = 2'd0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 2'd1;
        if (cnt == 2'd3) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait for the result register to free up
        if (!rsp_valid || rsp_ready) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.exec) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 2'd0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_accept_to_prep: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == S_PREP)
    else $error("accepted request did not start preparation");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && cnt == 2'd3 |=> state == S_EXEC)
    else $error("remainder did not finish after four steps");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp_valid && state == S_IDLE)
    else $error("commit did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !rsp_valid || rsp_ready)
    else $error("result overwritten before taken");

endmodule

// ----- rtl/kmac_dp.sv -----
// Datapath for the knob menu controller: config registers, menu state,
// heading nudge arithmetic, iterative remainder and result register.
// Depends on kmac_pkg.
module kmac_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [6:0]      cfg_data,
  input  kmac_pkg::req_t  req,
  input  kmac_pkg::cmd_t  cmd,
  output kmac_pkg::rsp_t  rsp
);
  import kmac_pkg::*;

  localparam logic [4:0] MODE_N = 5'(MODE_COUNT);
  localparam logic [4:0] DISP_N = 5'(MAX_DISPLAYS);
  localparam logic [4:0] VIEW_N = 5'(MAX_VIEWS);

  // config
  logic [6:0]  small_step, big_step;

  // menu state
  logic [1:0]  level, level_next;
  logic        engaged, engaged_next;
  logic [1:0]  last_mode, last_mode_next;
  logic [3:0]  highlight, highlight_next;
  logic [3:0]  chosen_display, chosen_display_next;
  logic        pending_valid, pending_valid_next;
  logic [15:0] pending_target, pending_target_next;

  // per-request working registers
  req_t        req_q;
  logic [15:0] seed;
  logic [13:0] delta;
  logic [4:0]  n;
  logic [4:0]  r;
  logic [3:0]  q;

  // prep-stage logic
  logic [15:0] seed_raw, seed_mod;
  logic [6:0]  step_deg;
  logic [13:0] delta_calc;
  logic [4:0]  dc_sat, vc_sat, n_sel;
  logic [4:0]  r_shift;

  // exec-stage logic
  logic [16:0] sum_up, sum_dn;
  logic [15:0] t_up, t_dn;
  logic [4:0]  w_up, w_dn;
  logic [3:0]  wrapped;
  logic        up;
  rsp_t        rsp_next;

  always_comb begin
    if (pending_valid) begin
      seed_raw = pending_target;
    end else if (req_q.ap_target_valid) begin
      seed_raw = req_q.ap_target_centideg;
    end else if (req_q.heading_valid) begin
      seed_raw = req_q.heading_centideg;
    end else begin
      seed_raw = 16'd0;
    end
    seed_mod = (seed_raw >= FULL_TURN) ? seed_raw - FULL_TURN : seed_raw;

    step_deg   = req_q.held ? big_step : small_step;
    // degrees * 100 = *64 + *32 + *4
    delta_calc = 14'({step_deg, 6'd0}) + 14'({step_deg, 5'd0}) + 14'({step_deg, 2'd0});

    dc_sat = (req_q.num_displays > DISP_N) ? DISP_N : req_q.num_displays;
    vc_sat = (req_q.num_views > VIEW_N) ? VIEW_N : req_q.num_views;
    unique case (level)
      LVL_MODE:    n_sel = MODE_N;
      LVL_DISPLAY: n_sel = dc_sat;
      default:     n_sel = vc_sat;
    endcase

    // restoring remainder, one dividend bit per step
    r_shift = {r[3:0], q[3]};
    if (r_shift >= n) begin
      r_shift = r_shift - n;
    end
  end

  always_comb begin
    up     = (req_q.req_type == EV_CW);
    sum_up = 17'(seed) + 17'(delta);
    sum_dn = 17'(seed) + 17'(FULL_TURN) - 17'(delta);
    t_up   = (sum_up >= 17'(FULL_TURN)) ? 16'(sum_up - 17'(FULL_TURN)) : sum_up[15:0];
    t_dn   = (sum_dn >= 17'(FULL_TURN)) ? 16'(sum_dn - 17'(FULL_TURN)) : sum_dn[15:0];

    w_up = (r + 5'd1 == n) ? 5'd0 : r + 5'd1;
    w_dn = (r == 5'd0) ? n - 5'd1 : r - 5'd1;
    if (n == 5'd0) begin
      wrapped = 4'd0;
    end else begin
      wrapped = up ? w_up[3:0] : w_dn[3:0];
    end

    level_next          = level;
    engaged_next        = engaged;
    last_mode_next      = last_mode;
    highlight_next      = highlight;
    chosen_display_next = chosen_display;
    pending_valid_next  = pending_valid;
    pending_target_next = pending_target;
    rsp_next            = '0;

    unique case (level)
      LVL_HOME: begin
        case (req_q.req_type)
          EV_CW, EV_CCW: begin
            rsp_next.action_kind     = ACT_TARGET;
            rsp_next.target_centideg = up ? t_up : t_dn;
            pending_valid_next       = 1'b1;
            pending_target_next      = up ? t_up : t_dn;
          end
          EV_CLICK: begin
            rsp_next.action_kind = ACT_MODE;
            engaged_next         = !engaged;
            rsp_next.mode_index  = engaged ? MODE_STANDBY : last_mode;
          end
          EV_LONG: begin
            level_next     = LVL_MODE;
            highlight_next = {2'd0, last_mode};
          end
          EV_DOUBLE: begin
            level_next     = LVL_DISPLAY;
            highlight_next = 4'd0;
          end
          default: ;
        endcase
      end
      LVL_MODE: begin
        case (req_q.req_type)
          EV_CW, EV_CCW: highlight_next = wrapped;
          EV_CLICK: begin
            level_next          = LVL_HOME;
            engaged_next        = (highlight != 4'd0);
            if (highlight != 4'd0) begin
              last_mode_next = highlight[1:0];
            end
            rsp_next.action_kind = ACT_MODE;
            rsp_next.mode_index  = highlight[1:0];
          end
          EV_DOUBLE: level_next = LVL_HOME;
          default: ;
        endcase
      end
      LVL_DISPLAY: begin
        case (req_q.req_type)
          EV_CW, EV_CCW: highlight_next = wrapped;
          EV_CLICK: begin
            chosen_display_next = highlight;
            level_next          = LVL_VIEW;
            highlight_next      = 4'd0;
          end
          EV_DOUBLE: level_next = LVL_HOME;
          default: ;
        endcase
      end
      default: begin
        case (req_q.req_type)
          EV_CW, EV_CCW: highlight_next = wrapped;
          EV_CLICK: begin
            rsp_next.action_kind   = ACT_VIEW;
            rsp_next.display_index = chosen_display;
            rsp_next.view_index    = highlight;
          end
          EV_DOUBLE: level_next = LVL_DISPLAY;
          default: ;
        endcase
      end
    endcase

    rsp_next.menu_level      = level_next;
    rsp_next.highlight_index = highlight_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      small_step     <= 7'd1;
      big_step       <= 7'd10;
      level          <= LVL_HOME;
      engaged        <= 1'b0;
      last_mode      <= MODE_AUTO;
      highlight      <= 4'd0;
      chosen_display <= 4'd0;
      pending_valid  <= 1'b0;
      pending_target <= 16'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SMALL_STEP: small_step <= cfg_data;
          REG_BIG_STEP:   big_step   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        level          <= level_next;
        engaged        <= engaged_next;
        last_mode      <= last_mode_next;
        highlight      <= highlight_next;
        chosen_display <= chosen_display_next;
        pending_valid  <= pending_valid_next;
        pending_target <= pending_target_next;
      end
    end
  end

  // working and result registers carry no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.prep) begin
      seed  <= seed_mod;
      delta <= delta_calc;
      n     <= n_sel;
      r     <= 5'd0;
      q     <= highlight;
    end
    if (cmd.div_step) begin
      r <= r_shift;
      q <= {q[2:0], 1'b0};
    end
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

  a_pending_in_range: assert property (@(posedge clk) disable iff (rst)
    pending_target < FULL_TURN)
    else $error("pending target out of range");

  a_mode_highlight: assert property (@(posedge clk) disable iff (rst)
    level == LVL_MODE |-> highlight < 4'(MODE_COUNT))
    else $error("mode picker highlight out of range");

  a_state_only_on_exec: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(level) && $stable(highlight) && $stable(pending_target))
    else $error("menu state changed outside commit");

endmodule

// ----- rtl/knob_menu_autopilot_controller.sv -----
// An accepted request passes the prep, remainder and commit states; its result
// is registered at commit; no new request is taken before then. The remainder,
// one bit per cycle, wraps the highlight by the current count. A result held in
// the output register lets the next request be accepted but stalls its commit.
// Reset (rst, synchronous, active high): home level, disengaged, last mode auto,
// no pending target, steps 1 and 10 degrees, no result pending.
module knob_menu_autopilot_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  kmac_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output kmac_pkg::rsp_t  rsp,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [6:0]      cfg_data
);
  import kmac_pkg::*;

  cmd_t cmd;

  kmac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  kmac_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .rsp       (rsp)
  );

endmodule

// ----- bench/tb.sv -----
// Testbench for knob_menu_autopilot_controller: directed knob script, then random phases.
// Each step setting is checked against a cycle-free model of the menu and nudge logic.
// Depends on kmac_pkg and the controller RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kmac_pkg::*;

  localparam logic [2:0] EV_UNUSED_LO = 3'd5;
  localparam logic [2:0] EV_UNUSED_HI = 3'd7;
  localparam logic [1:0] MODE_ROUTE   = 2'd3;
  localparam int STUCK_LIMIT   = 2000;
  localparam int DRAIN_SLACK   = 20;
  localparam int PHASE_ITEMS   = 145;

  typedef struct packed {
    req_t rq;
    logic known;
    rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_we;
  logic cfg_index;
  logic [6:0] cfg_data;

  knob_menu_autopilot_controller uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state, same reset as the block
  logic [1:0]  menu_lvl     = LVL_HOME;
  logic        ap_engaged   = 1'b0;
  logic [1:0]  last_mode    = MODE_AUTO;
  logic [3:0]  hl           = 4'd0;
  logic [3:0]  chosen_disp  = 4'd0;
  logic        tgt_pend_val = 1'b0;
  logic [15:0] tgt_pending  = 16'd0;
  logic [6:0]  small_step   = 7'd1;
  logic [6:0]  big_step     = 7'd10;

  rsp_t     expected_actions[$];
  dir_row_t knob_script[$];
  int       mismatches   = 0;
  int       idle_pct     = 0;
  int       stall_left   = 0;
  int       stuck_cycles = 0;
  logic [4:0] cur_dc = 5'd4;
  logic [4:0] cur_vc = 5'd4;

  function automatic int wrap_hl(int h, int n, logic up);
    if (n == 0) return 0;
    h = h % n;
    return up ? (h + 1) % n : (h + n - 1) % n;
  endfunction

  // one knob event through the menu; returns the action it causes
  function automatic rsp_t knob_step(req_t r);
    rsp_t o;
    int dc, vc, seed, delta, turn;
    logic turn_ev, cw;
    o = '0;
    turn = int'(FULL_TURN);
    dc = (int'(r.num_displays) > MAX_DISPLAYS) ? MAX_DISPLAYS : int'(r.num_displays);
    vc = (int'(r.num_views) > MAX_VIEWS) ? MAX_VIEWS : int'(r.num_views);
    turn_ev = (r.req_type == EV_CW) || (r.req_type == EV_CCW);
    cw = (r.req_type == EV_CW);
    case (menu_lvl)
      LVL_HOME: begin
        if (turn_ev) begin
          if (tgt_pend_val) seed = tgt_pending;
          else if (r.ap_target_valid) seed = r.ap_target_centideg;
          else if (r.heading_valid) seed = r.heading_centideg;
          else seed = 0;
          seed = seed % turn;
          delta = (int'(r.held ? big_step : small_step) * 100) % turn;
          tgt_pending = 16'(cw ? (seed + delta) % turn : (seed + turn - delta) % turn);
          tgt_pend_val = 1'b1;
          o.action_kind = ACT_TARGET;
          o.target_centideg = tgt_pending;
        end else if (r.req_type == EV_CLICK) begin
          o.action_kind = ACT_MODE;
          o.mode_index = ap_engaged ? MODE_STANDBY : last_mode;
          ap_engaged = !ap_engaged;
        end else if (r.req_type == EV_LONG) begin
          menu_lvl = LVL_MODE;
          hl = 4'(last_mode);
        end else if (r.req_type == EV_DOUBLE) begin
          menu_lvl = LVL_DISPLAY;
          hl = 4'd0;
        end
      end
      LVL_MODE: begin
        if (turn_ev) begin
          hl = 4'(wrap_hl(hl, MODE_COUNT, cw));
        end else if (r.req_type == EV_CLICK) begin
          menu_lvl = LVL_HOME;
          if (hl == 4'd0) begin
            ap_engaged = 1'b0;
          end else begin
            ap_engaged = 1'b1;
            last_mode = hl[1:0];
          end
          o.action_kind = ACT_MODE;
          o.mode_index = hl[1:0];
        end else if (r.req_type == EV_DOUBLE) begin
          menu_lvl = LVL_HOME;
        end
      end
      LVL_DISPLAY: begin
        if (turn_ev) begin
          hl = 4'(wrap_hl(hl, dc, cw));
        end else if (r.req_type == EV_CLICK) begin
          chosen_disp = hl;
          menu_lvl = LVL_VIEW;
          hl = 4'd0;
        end else if (r.req_type == EV_DOUBLE) begin
          menu_lvl = LVL_HOME;
        end
      end
      default: begin
        if (turn_ev) begin
          hl = 4'(wrap_hl(hl, vc, cw));
        end else if (r.req_type == EV_CLICK) begin
          o.action_kind = ACT_VIEW;
          o.display_index = chosen_disp;
          o.view_index = hl;
        end else if (r.req_type == EV_DOUBLE) begin
          menu_lvl = LVL_DISPLAY;
        end
      end
    endcase
    o.menu_level = menu_lvl;
    o.highlight_index = hl;
    return o;
  endfunction

  function automatic req_t knob(logic [2:0] ev, logic held, logic hv, logic [15:0] hdg,
                                logic av, logic [15:0] apt, logic [4:0] dc, logic [4:0] vc);
    return '{ev, held, hv, hdg, av, apt, dc, vc};
  endfunction

  function automatic rsp_t act(logic [1:0] kind, logic [1:0] mode, logic [15:0] tgt,
                               logic [3:0] disp, logic [3:0] view, logic [1:0] lvl,
                               logic [3:0] h);
    return '{kind, mode, tgt, disp, view, lvl, h};
  endfunction

  // mostly in range, now and then past 35999 up to the full 16 bits
  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 35999));
  endfunction

  // counts stay put for a while; one in eight lands above the maximum
  function automatic logic [4:0] pick_count();
    if ($urandom_range(0, 7) == 0) return 5'($urandom_range(MAX_DISPLAYS + 1, 31));
    return 5'($urandom_range(0, MAX_DISPLAYS));
  endfunction

  function automatic req_t rand_knob();
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 28) r.req_type = EV_CW;
    else if (pick < 56) r.req_type = EV_CCW;
    else if (pick < 74) r.req_type = EV_CLICK;
    else if (pick < 82) r.req_type = EV_LONG;
    else if (pick < 95) r.req_type = EV_DOUBLE;
    else r.req_type = 3'($urandom_range(EV_UNUSED_LO, EV_UNUSED_HI));
    if ($urandom_range(0, 7) == 0) cur_dc = pick_count();
    if ($urandom_range(0, 7) == 0) cur_vc = pick_count();
    r.held = 1'($urandom_range(0, 1));
    r.heading_valid = 1'($urandom_range(0, 1));
    r.heading_centideg = pick_angle();
    r.ap_target_valid = 1'($urandom_range(0, 1));
    r.ap_target_centideg = pick_angle();
    r.num_displays = cur_dc;
    r.num_views = cur_vc;
    return r;
  endfunction

  task automatic send_request(input req_t r, input logic known, input rsp_t want);
    rsp_t pred;
    if ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    pred = knob_step(r);
    expected_actions.push_back(known ? want : pred);
  endtask

  task automatic drain_actions();
    req_valid <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
  endtask

  task automatic set_steps(input logic [6:0] sm, input logic [6:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SMALL_STEP;
    cfg_data  <= sm;
    @(posedge clk);
    cfg_index <= REG_BIG_STEP;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_we <= 1'b0;
    small_step = sm;
    big_step   = bg;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_action(input rsp_t got);
    rsp_t want;
    if (expected_actions.size() == 0) begin
      $error("action with no request outstanding");
      mismatches++;
    end else begin
      want = expected_actions.pop_front();
      check_field("action_kind", want.action_kind, got.action_kind);
      check_field("mode_index", want.mode_index, got.mode_index);
      check_field("target_centideg", want.target_centideg, got.target_centideg);
      check_field("display_index", want.display_index, got.display_index);
      check_field("view_index", want.view_index, got.view_index);
      check_field("menu_level", want.menu_level, got.menu_level);
      check_field("highlight_index", want.highlight_index, got.highlight_index);
    end
  endtask

  // receiver: check what was taken at this edge, then pick ready for the next one
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) check_action(rsp);
    if (idle_pct == 0) begin
      stall_left = 0;
      rsp_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if ($urandom_range(0, 399) < idle_pct) begin
      stall_left = $urandom_range(0, 12);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("** knob_menu_autopilot_controller: FAILED **");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  int phase_idle[5] = '{30, 0, 50, 15, 0};

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_SMALL_STEP;
    cfg_data  = '0;

    // default steps 1 and 10 degrees
    knob_script.push_back(dir_row_t'{knob(EV_CLICK, 0, 0, 0, 0, 0, 4, 4), 1'b1,
      act(ACT_MODE, MODE_AUTO, 0, 0, 0, LVL_HOME, 0)});
    knob_script.push_back(dir_row_t'{knob(EV_CLICK, 1, 1, 35999, 1, 35999, 4, 4), 1'b1,
      act(ACT_MODE, MODE_STANDBY, 0, 0, 0, LVL_HOME, 0)});
    // first nudge seeds from a heading past a full turn
    knob_script.push_back(dir_row_t'{knob(EV_CW, 0, 1, 16'hFFFF, 0, 0, 4, 4), 1'b1,
      act(ACT_TARGET, MODE_STANDBY, 29635, 0, 0, LVL_HOME, 0)});
    // pending target wins over the reported one
    knob_script.push_back(dir_row_t'{knob(EV_CCW, 1, 1, 0, 1, 35999, 4, 4), 1'b1,
      act(ACT_TARGET, MODE_STANDBY, 28635, 0, 0, LVL_HOME, 0)});
    knob_script.push_back(dir_row_t'{knob(EV_UNUSED_LO, 1, 1, 0, 1, 0, 31, 31), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_HOME, 0)});
    knob_script.push_back(dir_row_t'{knob(EV_LONG, 0, 0, 0, 0, 0, 4, 4), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_MODE, 1)});
    knob_script.push_back(dir_row_t'{knob(EV_LONG, 0, 0, 0, 0, 0, 4, 4), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_MODE, 1)});
    knob_script.push_back(dir_row_t'{knob(EV_CCW, 0, 0, 0, 0, 0, 4, 4), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_MODE, 0)});
    knob_script.push_back(dir_row_t'{knob(EV_CCW, 0, 0, 0, 0, 0, 4, 4), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_MODE, 3)});
    knob_script.push_back(dir_row_t'{knob(EV_CLICK, 0, 0, 0, 0, 0, 4, 4), 1'b1,
      act(ACT_MODE, MODE_ROUTE, 0, 0, 0, LVL_HOME, 3)});
    knob_script.push_back(dir_row_t'{knob(EV_CLICK, 0, 0, 0, 0, 0, 4, 4), 1'b1,
      act(ACT_MODE, MODE_STANDBY, 0, 0, 0, LVL_HOME, 3)});
    knob_script.push_back(dir_row_t'{knob(EV_DOUBLE, 0, 0, 0, 0, 0, 4, 4), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_DISPLAY, 0)});
    // no displays at all
    knob_script.push_back(dir_row_t'{knob(EV_CW, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_DISPLAY, 0)});
    // count above the maximum saturates, ccw wraps from 0
    knob_script.push_back(dir_row_t'{knob(EV_CCW, 0, 0, 0, 0, 0, 31, 31), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_DISPLAY, 15)});
    // highlight left beyond a smaller count
    knob_script.push_back(dir_row_t'{knob(EV_CW, 0, 0, 0, 0, 0, 5, 5), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_DISPLAY, 1)});
    knob_script.push_back(dir_row_t'{knob(EV_LONG, 0, 0, 0, 0, 0, 5, 5), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_DISPLAY, 1)});
    knob_script.push_back(dir_row_t'{knob(EV_CLICK, 0, 0, 0, 0, 0, 5, 5), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_VIEW, 0)});
    knob_script.push_back(dir_row_t'{knob(EV_CCW, 0, 0, 0, 0, 0, 5, 31), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_VIEW, 15)});
    knob_script.push_back(dir_row_t'{knob(EV_CLICK, 0, 0, 0, 0, 0, 5, 31), 1'b1,
      act(ACT_VIEW, MODE_STANDBY, 0, 1, 15, LVL_VIEW, 15)});
    knob_script.push_back(dir_row_t'{knob(EV_CW, 0, 0, 0, 0, 0, 5, 0), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_VIEW, 0)});
    knob_script.push_back(dir_row_t'{knob(EV_DOUBLE, 0, 0, 0, 0, 0, 5, 5), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_DISPLAY, 0)});
    knob_script.push_back(dir_row_t'{knob(EV_DOUBLE, 0, 0, 0, 0, 0, 5, 5), 1'b1,
      act(ACT_NONE, MODE_STANDBY, 0, 0, 0, LVL_HOME, 0)});
    knob_script.push_back(dir_row_t'{knob(EV_CW, 1, 1, 100, 1, 200, 5, 5), 1'b0, '0});
    knob_script.push_back(dir_row_t'{knob(EV_LONG, 0, 0, 0, 0, 0, 5, 5), 1'b0, '0});
    knob_script.push_back(dir_row_t'{knob(EV_CW, 0, 0, 0, 0, 0, 5, 5), 1'b0, '0});
    // picking standby in the mode picker disengages
    knob_script.push_back(dir_row_t'{knob(EV_CLICK, 0, 0, 0, 0, 0, 5, 5), 1'b0, '0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    foreach (knob_script[i])
      send_request(knob_script[i].rq, knob_script[i].known, knob_script[i].want);

    for (int p = 0; p < 5; p++) begin
      logic [6:0] sm, bg;
      drain_actions();
      sm = 7'($urandom_range(1, 90));
      bg = 7'($urandom_range(1, 90));
      if (p == 0) begin
        sm = 7'd90;
        bg = 7'd90;
      end else if (p == 1) begin
        sm = 7'd1;
        bg = 7'd1;
      end else if (p == 3) begin
        sm = 7'd90;
        bg = 7'd1;
      end
      set_steps(sm, bg);
      idle_pct = phase_idle[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_request(rand_knob(), 1'b0, '0);
      end
    end

    drain_actions();
    repeat (DRAIN_SLACK) @(posedge clk);
    if (mismatches == 0) begin
      $display("** knob_menu_autopilot_controller: PASSED **");
    end else begin
      $display("** knob_menu_autopilot_controller: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/kmac_pkg.sv
rtl/kmac_ctrl.sv
rtl/kmac_dp.sv
rtl/knob_menu_autopilot_controller.sv
bench/tb.sv
